/* design/ctph_pkg.sv */
`default_nettype none
package ctph_pkg;

	// Document byte and signature result as they travel on the channels
	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} doc_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] position;
		logic [6:0] char_code;
		logic       run_end;
	} sig_item_t;

	// Result kinds
	localparam logic [1:0] KIND_SIG1 = 2'd0;
	localparam logic [1:0] KIND_SIG2 = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Register indexes (byte address bit 2)
	localparam logic REG_BLK_LEN = 1'b0;
	localparam logic REG_SKIP_WS = 1'b1;

	// Defaults for the top-level parameters
	localparam int WINDOW_LEN_DEF = 7;
	localparam int SIG_LEN_DEF    = 64;

	// Hash widths and constants
	localparam int          ROLL_W     = 32;
	localparam int          BS_W       = 31;
	localparam int          DIV_STEPS  = ROLL_W;
	localparam int          DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam logic [31:0] FNV_MULT   = 32'h0100_0193;
	localparam logic [31:0] PIECE_INIT = 32'h2802_1967;
	localparam logic [30:0] BS_RESET   = 31'd3;

	// Control of the rolling window unit
	typedef struct packed {
		logic upd;    // shift the byte into the window sums
		logic fold;   // combine the sums into the rolling hash
		logic clear;  // end of document
	} ctph_roll_ctl_t;

	// Control of the piece hash unit
	typedef struct packed {
		logic start;
		logic init_a;
		logic init_b;
		logic clear;
	} ctph_fnv_ctl_t;

	// Status of the trigger divider
	typedef struct packed {
		logic busy;
		logic hit_a;
		logic hit_b;
	} ctph_div_st_t;

	// Base64 alphabet
	function automatic logic [6:0] b64_char(input logic [5:0] idx);
		logic [6:0] i7;
		i7 = {1'b0, idx};
		priority if (idx < 6'd26) begin
			return 7'h41 + i7;
		end else if (idx < 6'd52) begin
			return 7'h61 + i7 - 7'd26;
		end else if (idx < 6'd62) begin
			return 7'h30 + i7 - 7'd52;
		end else if (idx == 6'd62) begin
			return 7'h2B;
		end else begin
			return 7'h2F;
		end
	endfunction

endpackage
`default_nettype wire

/* design/ctph_roll.sv */
`default_nettype none
module ctph_roll import ctph_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ctph_roll_ctl_t ctl,
	input  wire logic [7:0]     c,
	output logic [ROLL_W-1:0]   last_roll
);

	localparam int SLOT_W = $clog2(WINDOW_LEN);

	logic [7:0]        bytes_q [WINDOW_LEN];
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       window_sum_q;
	logic [31:0]       weighted_sum_q;
	logic [31:0]       shift_hash_q;
	logic [31:0]       last_roll_q;

	logic [7:0]        old_byte;
	logic [SLOT_W-1:0] slot_nxt;
	logic [31:0]       c32;

	// oldest byte leaves, new byte enters at the same slot
	assign old_byte = bytes_q[slot_q];
	assign slot_nxt = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
	assign c32      = {24'd0, c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) bytes_q[i] <= '0;
			slot_q         <= '0;
			window_sum_q   <= '0;
			weighted_sum_q <= '0;
			shift_hash_q   <= '0;
			last_roll_q    <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < WINDOW_LEN; i++) bytes_q[i] <= '0;
			slot_q         <= '0;
			window_sum_q   <= '0;
			weighted_sum_q <= '0;
			shift_hash_q   <= '0;
			last_roll_q    <= '0;
		end else if (ctl.upd) begin
			bytes_q[slot_q] <= c;
			slot_q          <= slot_nxt;
			window_sum_q    <= window_sum_q + c32 - {24'd0, old_byte};
			weighted_sum_q  <= weighted_sum_q - window_sum_q + c32 * 32'(WINDOW_LEN);
			shift_hash_q    <= {shift_hash_q[26:0], 5'd0} ^ c32;
		end else if (ctl.fold) begin
			last_roll_q <= window_sum_q + weighted_sum_q + shift_hash_q;
		end
	end

	assign last_roll = last_roll_q;

endmodule
`default_nettype wire

/* design/ctph_div.sv */
`default_nettype none
module ctph_div import ctph_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ROLL_W-1:0] dividend,
	input  wire logic [BS_W-1:0]   divisor,
	output ctph_div_st_t           st
);

	// Restoring divider, one quotient bit per cycle. Only the remainder and
	// the quotient's low bit are kept: roll mod 2*bs hits 2*bs-1 exactly when
	// roll mod bs hits bs-1 and the quotient is odd.
	logic [ROLL_W-1:0]    quo_q;
	logic [BS_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 hit_a_q;
	logic                 hit_b_q;

	logic [BS_W:0]   trial;
	logic            ge;
	logic [BS_W-1:0] rem_nxt;

	assign trial   = {rem_q, quo_q[ROLL_W-1]};
	assign ge      = trial >= {1'b0, divisor};
	assign rem_nxt = ge ? BS_W'(trial - {1'b0, divisor}) : trial[BS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q  <= 1'b0;
				hit_a_q <= rem_nxt == BS_W'(divisor - 1'b1);
				hit_b_q <= (rem_nxt == BS_W'(divisor - 1'b1)) && ge;
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[ROLL_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign st.busy  = busy_q;
	assign st.hit_a = hit_a_q;
	assign st.hit_b = hit_b_q;

endmodule
`default_nettype wire

/* design/ctph_fnv.sv */
`default_nettype none
module ctph_fnv import ctph_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ctph_fnv_ctl_t ctl,
	input  wire logic [7:0]    c,
	output logic [31:0]        hash_a,
	output logic [31:0]        hash_b,
	output logic               busy
);

	// Shift-and-add multiply by the FNV prime, one multiplier bit per
	// cycle, both piece hashes side by side.
	logic [31:0]          hash_a_q, hash_b_q;
	logic [31:0]          acc_a_q, acc_b_q;
	logic [31:0]          sh_a_q, sh_b_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	logic        mbit;
	logic [31:0] acc_a_nxt, acc_b_nxt;

	assign mbit      = FNV_MULT[cnt_q];
	assign acc_a_nxt = acc_a_q + (mbit ? sh_a_q : 32'd0);
	assign acc_b_nxt = acc_b_q + (mbit ? sh_b_q : 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_a_q <= PIECE_INIT;
			hash_b_q <= PIECE_INIT;
			busy_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (ctl.clear) begin
			hash_a_q <= PIECE_INIT;
			hash_b_q <= PIECE_INIT;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q   <= 1'b0;
				hash_a_q <= acc_a_nxt ^ {24'd0, c};
				hash_b_q <= acc_b_nxt ^ {24'd0, c};
			end
		end else begin
			if (ctl.init_a) hash_a_q <= PIECE_INIT;
			if (ctl.init_b) hash_b_q <= PIECE_INIT;
		end
	end

	// partial product registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
			sh_a_q  <= hash_a_q;
			sh_b_q  <= hash_b_q;
		end else if (busy_q) begin
			acc_a_q <= acc_a_nxt;
			acc_b_q <= acc_b_nxt;
			sh_a_q  <= {sh_a_q[30:0], 1'b0};
			sh_b_q  <= {sh_b_q[30:0], 1'b0};
		end
	end

	assign hash_a = hash_a_q;
	assign hash_b = hash_b_q;
	assign busy   = busy_q;

endmodule
`default_nettype wire

/* design/ctph_signature_stream_top.sv */
// Spamsum-style piecewise hash of a document byte stream. Each accepted
// item (one byte) not skipped as whitespace updates a window rolling hash
// and two FNV piece hashes; when the rolling hash modulo the block size (or
// twice the block size) hits its trigger, a base64 character is sent for
// the first (or second) signature, and the final byte of a document adds
// the closing characters and an end marker, the last result of each item
// flagged by run_end. One item is in work at a time: a hashed byte passes
// states UPD, ROLL, START and WAIT, where the 32-step serial divider finds
// the trigger remainder and the piece hash multiplies run bit-serially
// alongside, then gives one result per cycle when the output side takes
// them at once. A byte skipped as whitespace and not last is only accepted.
// Registers: block size at 0x0 (zero acts as one), skip_whitespace at 0x4;
// write them only while the block is idle.
`default_nettype none
module ctph_signature_stream_top import ctph_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int SIG_LEN    = SIG_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// document bytes
	input  wire logic        doc_valid,
	output logic             doc_ready,
	input  wire doc_item_t   doc_item,
	// signature results
	output logic             sig_valid,
	input  wire logic        sig_ready,
	output sig_item_t        sig_item,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int PA_W = $clog2(SIG_LEN);
	localparam int PB_W = $clog2(SIG_LEN / 2);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UPD   = 3'd1;
	localparam logic [2:0] S_ROLL  = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	// pending result bits, in output order
	localparam int P_HIT_A   = 0;
	localparam int P_HIT_B   = 1;
	localparam int P_CLOSE_A = 2;
	localparam int P_CLOSE_B = 3;
	localparam int P_END     = 4;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	logic [BS_W-1:0] blk_len_q;
	logic            skip_ws_q;
	logic [2:0]      state_q;
	logic [7:0]      byte_q;
	logic            last_q;
	logic [4:0]      pend_q;
	logic [PA_W-1:0] pos_a_q;
	logic [PB_W-1:0] pos_b_q;
	logic            sig_valid_q;
	sig_item_t       sig_item_q;

	logic            cfg_wr;
	logic [BS_W-1:0] bs_eff;
	logic            accept;
	logic            skip;
	logic            close_now;
	logic            close_run;
	logic [4:0]      pend_run;
	logic [4:0]      sel;
	logic [4:0]      pend_rest;
	logic            emit;
	logic            adv_a;
	logic            adv_b;
	sig_item_t       res_nxt;

	logic [ROLL_W-1:0] last_roll;
	logic [31:0]       hash_a;
	logic [31:0]       hash_b;
	logic              fnv_busy;
	ctph_roll_ctl_t    roll_ctl;
	ctph_fnv_ctl_t     fnv_ctl;
	ctph_div_st_t      div_st;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= BS_RESET;
			skip_ws_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BLK_LEN: blk_len_q <= pwdata[BS_W-1:0];
				REG_SKIP_WS: skip_ws_q <= pwdata[0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BLK_LEN: prdata = {1'b0, blk_len_q};
			REG_SKIP_WS: prdata = {31'd0, skip_ws_q};
			default:     prdata = '0;
		endcase
	end

	assign bs_eff = (blk_len_q == '0) ? BS_W'(1) : blk_len_q;

	// hashing units
	ctph_roll #(.WINDOW_LEN(WINDOW_LEN)) u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (roll_ctl),
		.c         (byte_q),
		.last_roll (last_roll)
	);

	ctph_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (last_roll),
		.divisor  (bs_eff),
		.st       (div_st)
	);

	ctph_fnv u_fnv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fnv_ctl),
		.c      (byte_q),
		.hash_a (hash_a),
		.hash_b (hash_b),
		.busy   (fnv_busy)
	);

	// handshake and result planning
	assign doc_ready = (state_q == S_IDLE);
	assign accept    = doc_valid && doc_ready;
	assign skip      = skip_ws_q && is_blank(doc_item.byte_value);
	assign close_now = doc_item.last_byte && (last_roll != '0);
	assign close_run = last_q && (last_roll != '0);
	assign pend_run  = {last_q, close_run, close_run, div_st.hit_b, div_st.hit_a};

	assign sel       = pend_q & (~pend_q + 5'd1);
	assign pend_rest = pend_q & ~sel;
	assign emit      = (state_q == S_EMIT) && (!sig_valid_q || sig_ready);
	assign adv_a     = pos_a_q < PA_W'(SIG_LEN - 1);
	assign adv_b     = pos_b_q < PB_W'(SIG_LEN / 2 - 1);

	// unit control
	assign roll_ctl.upd   = (state_q == S_UPD);
	assign roll_ctl.fold  = (state_q == S_ROLL);
	assign roll_ctl.clear = emit && sel[P_END];
	assign fnv_ctl.start  = (state_q == S_START);
	assign fnv_ctl.init_a = emit && sel[P_HIT_A] && adv_a;
	assign fnv_ctl.init_b = emit && sel[P_HIT_B] && adv_b;
	assign fnv_ctl.clear  = emit && sel[P_END];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= '0;
			byte_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						byte_q <= doc_item.byte_value;
						last_q <= doc_item.last_byte;
						if (!skip) begin
							state_q <= S_UPD;
						end else if (doc_item.last_byte) begin
							pend_q  <= {1'b1, close_now, close_now, 2'b00};
							state_q <= S_EMIT;
						end
					end
				end
				S_UPD:   state_q <= S_ROLL;
				S_ROLL:  state_q <= S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (!div_st.busy && !fnv_busy) begin
						pend_q  <= pend_run;
						state_q <= (pend_run != '0) ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (emit) begin
						pend_q <= pend_rest;
						if (pend_rest == '0) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// signature positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_a_q <= '0;
			pos_b_q <= '0;
		end else if (emit) begin
			if (sel[P_END]) begin
				pos_a_q <= '0;
				pos_b_q <= '0;
			end else if (sel[P_HIT_A] && adv_a) begin
				pos_a_q <= pos_a_q + 1'b1;
			end else if (sel[P_HIT_B] && adv_b) begin
				pos_b_q <= pos_b_q + 1'b1;
			end
		end
	end

	// next result item
	always_comb begin
		res_nxt.run_end = (pend_rest == '0);
		priority if (sel[P_HIT_A] || sel[P_CLOSE_A]) begin
			res_nxt.kind      = KIND_SIG1;
			res_nxt.position  = 6'(pos_a_q);
			res_nxt.char_code = b64_char(hash_a[5:0]);
		end else if (sel[P_HIT_B] || sel[P_CLOSE_B]) begin
			res_nxt.kind      = KIND_SIG2;
			res_nxt.position  = 6'(pos_b_q);
			res_nxt.char_code = b64_char(hash_b[5:0]);
		end else begin
			res_nxt.kind      = KIND_END;
			res_nxt.position  = '0;
			res_nxt.char_code = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_valid_q <= 1'b0;
		end else if (emit) begin
			sig_valid_q <= 1'b1;
		end else if (sig_ready) begin
			sig_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) sig_item_q <= res_nxt;
	end

	assign sig_valid = sig_valid_q;
	assign sig_item  = sig_item_q;

	// checks
	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy == fnv_busy)
		else $error("divider and piece hash units out of step");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !res_nxt.run_end |=> state_q == S_EMIT && pend_q != '0)
		else $error("results of an item stopped before run_end");

	a_doc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit && sel[P_END] |=> pos_a_q == '0 && pos_b_q == '0 && last_roll == '0)
		else $error("document state not cleared after end marker");

	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> !div_st.busy && pend_q != '0)
		else $error("result sequencing while divider is busy");

endmodule
`default_nettype wire
